>>> src/scl_pkg.sv
// shared types and constants for the serial command led blinker
// no dependencies; imported by scl_parser, scl_blink and the top level
package scl_pkg;

  localparam int MAX_LINE_DEF = 30;
  localparam logic [15:0] DEFAULT_MS = 16'd500;

  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    REPLY_NONE   = 2'd0,
    REPLY_ACCEPT = 2'd1,
    REPLY_ERROR  = 2'd2
  } reply_t;

  // parser to blinker: line end seen and the decoded command
  typedef struct packed {
    logic        term;
    logic        accept;
    logic        enable;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } cmd_t;

  // blinker settings and led level after the current transaction
  typedef struct packed {
    logic        led;
    logic        enable;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } blink_view_t;

  function automatic logic [15:0] mul10_add(input logic [15:0] acc, input logic [3:0] dig);
    logic [15:0] sum;
    sum = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {12'd0, dig};
    return sum;
  endfunction

endpackage

>>> src/scl_parser.sv
// line parser: tracks the LED:<0|1>:<on>:<off> syntax and line length
// depends on scl_pkg
module scl_parser #(
  parameter int MAX_LINE = scl_pkg::MAX_LINE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          is_byte,
  input  logic [7:0]    rx_byte,
  output scl_pkg::cmd_t cmd
);
  import scl_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE - 1);

  typedef enum logic [3:0] {
    PH_L, PH_E, PH_D, PH_C1, PH_EN, PH_C2, PH_ON0, PH_ON, PH_OFF0, PH_OFF, PH_BAD
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             bad_r, bad_nxt;
  logic             pen_r, pen_nxt;
  logic [15:0]      pon_r, pon_nxt;
  logic [15:0]      poff_r, poff_nxt;

  logic is_term, is_dig;
  logic [15:0] on_acc, off_acc;

  assign is_term = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_dig  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign on_acc  = mul10_add(pon_r, rx_byte[3:0]);
  assign off_acc = mul10_add(poff_r, rx_byte[3:0]);

  assign cmd.term   = is_byte && is_term;
  assign cmd.accept = is_byte && is_term && (phase_r == PH_OFF) && !bad_r;
  assign cmd.enable = pen_r;
  assign cmd.on_ms  = pon_r;
  assign cmd.off_ms = poff_r;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    bad_nxt   = bad_r;
    pen_nxt   = pen_r;
    pon_nxt   = pon_r;
    poff_nxt  = poff_r;
    if (is_byte && is_term) begin
      phase_nxt = PH_L;
      len_nxt   = '0;
      bad_nxt   = 1'b0;
    end else if (is_byte) begin
      if (len_r >= LEN_MAX) begin
        bad_nxt = 1'b1;
      end else begin
        len_nxt = len_r + 1'b1;
      end
      case (phase_r)
        PH_L:  phase_nxt = (rx_byte == CH_L) ? PH_E : PH_BAD;
        PH_E:  phase_nxt = (rx_byte == CH_E) ? PH_D : PH_BAD;
        PH_D:  phase_nxt = (rx_byte == CH_D) ? PH_C1 : PH_BAD;
        PH_C1: phase_nxt = (rx_byte == CH_COLON) ? PH_EN : PH_BAD;
        PH_EN: begin
          if (rx_byte == CH_ZERO || rx_byte == CH_ONE) begin
            pen_nxt   = (rx_byte == CH_ONE);
            phase_nxt = PH_C2;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_C2: begin
          if (rx_byte == CH_COLON) begin
            pon_nxt   = '0;
            phase_nxt = PH_ON0;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_ON0, PH_ON: begin
          if (is_dig) begin
            pon_nxt   = on_acc;
            phase_nxt = PH_ON;
          end else if (phase_r == PH_ON && rx_byte == CH_COLON) begin
            poff_nxt  = '0;
            phase_nxt = PH_OFF0;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_OFF0, PH_OFF: begin
          if (is_dig) begin
            poff_nxt  = off_acc;
            phase_nxt = PH_OFF;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        default: phase_nxt = PH_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_L;
      len_r   <= '0;
      bad_r   <= 1'b0;
      pen_r   <= 1'b0;
      pon_r   <= '0;
      poff_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      bad_r   <= bad_nxt;
      pen_r   <= pen_nxt;
      pon_r   <= pon_nxt;
      poff_r  <= poff_nxt;
    end
  end

  // an accepted line always has a clean length
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (len_r <= LEN_MAX))
    else $error("accept with overlong line");

  // a terminator always returns the parser to the line start
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && cmd.term) |=> (phase_r == PH_L) && (len_r == '0) && !bad_r)
    else $error("parser not cleared after line end");

  // the length counter never runs past its saturation point
  assert property (@(posedge clk) disable iff (!rst_n) len_r <= LEN_MAX)
    else $error("line length overflow");

endmodule

>>> src/scl_blink.sv
// blink settings and on/off phase counter driven by millisecond ticks
// depends on scl_pkg
module scl_blink (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 is_tick,
  input  scl_pkg::cmd_t        cmd,
  output scl_pkg::blink_view_t view_nxt
);
  import scl_pkg::*;

  logic        en_r, en_nxt;
  logic [15:0] on_r, on_nxt;
  logic [15:0] off_r, off_nxt;
  logic        offph_r, offph_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic        running;
  logic [15:0] dur, tick_inc;

  assign running  = en_r && (on_r != '0) && (off_r != '0);
  assign dur      = offph_r ? off_r : on_r;
  assign tick_inc = ticks_r + 16'd1;

  always_comb begin
    en_nxt    = en_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    offph_nxt = offph_r;
    ticks_nxt = ticks_r;
    if (is_tick) begin
      if (running) begin
        if (tick_inc >= dur) begin
          offph_nxt = !offph_r;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = tick_inc;
        end
      end else begin
        offph_nxt = 1'b0;
        ticks_nxt = '0;
      end
    end else if (cmd.accept) begin
      en_nxt    = cmd.enable;
      on_nxt    = cmd.on_ms;
      off_nxt   = cmd.off_ms;
      offph_nxt = 1'b0;
      ticks_nxt = '0;
    end
  end

  always_comb begin
    view_nxt.enable = en_nxt;
    view_nxt.on_ms  = on_nxt;
    view_nxt.off_ms = off_nxt;
    if (!en_nxt || on_nxt == '0) begin
      view_nxt.led = 1'b0;
    end else if (off_nxt == '0) begin
      view_nxt.led = 1'b1;
    end else begin
      view_nxt.led = !offph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      on_r    <= DEFAULT_MS;
      off_r   <= DEFAULT_MS;
      offph_r <= 1'b0;
      ticks_r <= '0;
    end else if (step) begin
      en_r    <= en_nxt;
      on_r    <= on_nxt;
      off_r   <= off_nxt;
      offph_r <= offph_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // a new command restarts the cycle at the start of the on phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && !is_tick && cmd.accept) |=> !offph_r && (ticks_r == '0))
    else $error("blink cycle not restarted on command");

  // the counter only runs while blinking
  assert property (@(posedge clk) disable iff (!rst_n)
    !running |-> (ticks_r == '0) || $past(step && !is_tick))
    else $error("phase counter running while stopped");

endmodule

>>> src/serial_command_led_blinker.sv
// top level of the serial command led blinker: handshake stages and result register
// depends on scl_pkg, scl_parser, scl_blink
//
//   channel | ports                           | direction
//   in      | in_valid in_stall in_kind in_rx_byte | byte or ms tick into the block
//   out     | out_valid out_stall out_led_out out_reply out_enabled_now
//           | out_on_time_now out_off_time_now | one result per input transaction
//
// each transaction passes through the input register and then the result register
// one transaction per cycle is sustained while out_stall is low; out_valid is loaded from
// the input register's valid bit whenever the result register can take a new value
// reset loads enable 1 and 500 ms on / 500 ms off, parser at the line start
// out_stall holds the result register; the input register keeps accepting until it is full
module serial_command_led_blinker #(
  parameter int MAX_LINE = scl_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_led_out,
  output logic [1:0]  out_reply,
  output logic        out_enabled_now,
  output logic [15:0] out_on_time_now,
  output logic [15:0] out_off_time_now
);
  import scl_pkg::*;

  // input register
  logic       in_valid_r;
  logic       in_kind_r;
  logic [7:0] in_byte_r;

  // result register
  logic        out_valid_r;
  logic        led_r;
  reply_t      reply_r, reply_nxt;
  logic        en_out_r;
  logic [15:0] on_out_r;
  logic [15:0] off_out_r;

  logic        adv;   // result register can take a new value
  logic        step;  // transaction moves from input to result register
  cmd_t        cmd;
  blink_view_t view_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign step     = adv && in_valid_r;
  assign in_stall = in_valid_r && !adv;

  scl_parser #(.MAX_LINE(MAX_LINE)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .is_byte (!in_kind_r),
    .rx_byte (in_byte_r),
    .cmd     (cmd)
  );

  scl_blink u_blink (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .is_tick  (in_kind_r),
    .cmd      (cmd),
    .view_nxt (view_nxt)
  );

  // reply only on line terminators
  always_comb begin
    if (cmd.accept) begin
      reply_nxt = REPLY_ACCEPT;
    end else if (cmd.term) begin
      reply_nxt = REPLY_ERROR;
    end else begin
      reply_nxt = REPLY_NONE;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_kind_r <= in_kind;
      in_byte_r <= in_rx_byte;
    end
    if (step) begin
      led_r     <= view_nxt.led;
      reply_r   <= reply_nxt;
      en_out_r  <= view_nxt.enable;
      on_out_r  <= view_nxt.on_ms;
      off_out_r <= view_nxt.off_ms;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_out      = led_r;
  assign out_reply        = reply_r;
  assign out_enabled_now  = en_out_r;
  assign out_on_time_now  = on_out_r;
  assign out_off_time_now = off_out_r;

  // a tick transaction never carries a reply
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_kind_r) |=> (out_reply == REPLY_NONE))
    else $error("reply on a tick");

  // led is only lit when enabled with a nonzero on time
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_led_out) |-> (out_enabled_now && out_on_time_now != '0))
    else $error("led on while disabled or zero on time");

  // enabled with a nonzero on time and zero off time keeps the led lit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_enabled_now && out_on_time_now != '0 && out_off_time_now == '0)
      |-> out_led_out)
    else $error("led off with zero off time");

endmodule
